// ----- src/sparse_complex_matrix_multiply_assert.svh -----
// Assertion macros for the sparse complex matrix multiply checker.
`ifndef SPARSE_COMPLEX_MATRIX_MULTIPLY_ASSERT_SVH
`define SPARSE_COMPLEX_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define SCMM_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define SCMM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- src/scmm_pkg.sv -----
// ----------------------------------------------------------------------------
// scmm_pkg
// Shared sizes, codes, command/status bundles and helpers of the sparse
// complex matrix multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package scmm_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int MAX_NNZ   = 1024;
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int NNZ_W     = $clog2(MAX_NNZ + 1);
   localparam int ADDR_W    = $clog2(MAX_NNZ);
   localparam int DIM_W     = 7;
   localparam int EPS_W     = 63;
   localparam int VAL_W     = 16;
   localparam int ACC_W     = 40;
   localparam int HALF_W    = ACC_W / 2;
   localparam int SQ_W      = 2 * ACC_W;
   localparam int CSR_IDX_W = 2;
   localparam int ENT_W     = COL_W + 2 * VAL_W;
   localparam int RNG_W     = 2 * NNZ_W;

   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_ORDER = 2'd3
   } status_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_ROWS    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_B_COLS    = 2'd2,
      CSR_EPS_SQ    = 2'd3
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic arng_rd;
      logic arng_take;
      logic aent_rd;
      logic aent_take;
      logic brng_take;
      logic bent_rd;
      logic bent_take;
      logic mul;
      logic acc_add;
      logic scan_rd;
      logic mag1;
      logic mag2;
      logic mag3;
      logic mag4;
      logic keep_step;
      logic col_step;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic go;
      logic a_more;
      logic b_more;
      logic touched;
      logic need_out;
      logic last_col;
   } stat_type;

   typedef struct packed {
      logic [ROW_W-1:0]        out_row;
      logic [COL_W-1:0]        out_col;
      logic signed [ACC_W-1:0] out_re;
      logic signed [ACC_W-1:0] out_im;
      logic                    empty_row;
      logic                    last;
      logic [1:0]              status;
   } rsp_word_type;

   // saturate a grown sum to the accumulator range
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
      logic signed [ACC_W-1:0] r;
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
      return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
   endfunction

endpackage

`default_nettype wire

// ----- src/scmm_if.sv -----
// ----------------------------------------------------------------------------
// scmm_if
// Request, response and register-write channels (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface scmm_req_if import scmm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic [ROW_W-1:0]        row;
   logic [COL_W-1:0]        col;
   logic signed [VAL_W-1:0] val_re;
   logic signed [VAL_W-1:0] val_im;
   modport source (output valid, req_type, row, col, val_re, val_im, input ready);
   modport sink   (input valid, req_type, row, col, val_re, val_im, output ready);
endinterface

interface scmm_rsp_if import scmm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        out_row;
   logic [COL_W-1:0]        out_col;
   logic signed [ACC_W-1:0] out_re;
   logic signed [ACC_W-1:0] out_im;
   logic                    empty_row;
   logic                    last;
   logic [1:0]              status;
   modport source (output valid, out_row, out_col, out_re, out_im, empty_row, last,
                   status, input ready);
   modport sink   (input valid, out_row, out_col, out_re, out_im, empty_row, last,
                   status, output ready);
endinterface

interface scmm_csr_if import scmm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [EPS_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/scmm_ram.sv -----
// ----------------------------------------------------------------------------
// scmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/scmm_datapath.sv -----
// ----------------------------------------------------------------------------
// scmm_datapath
// Matrix stores, row ranges, accumulator, complex MAC, magnitude test and
// the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module scmm_datapath import scmm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic [1:0]              req_type,
   input  wire logic [ROW_W-1:0]        req_row,
   input  wire logic [COL_W-1:0]        req_col,
   input  wire logic signed [VAL_W-1:0] req_val_re,
   input  wire logic signed [VAL_W-1:0] req_val_im,
   scmm_csr_if.sink                     csr,
   scmm_rsp_if.source                   rsp
);

   // config
   logic [DIM_W-1:0] a_rows_ff, inner_dim_ff, b_cols_ff;
   logic [EPS_W-1:0] eps_sq_ff;

   // matrix bookkeeping
   logic [NNZ_W-1:0]    a_cnt_ff, b_cnt_ff, a_cs_ff, b_cs_ff;
   logic [ROW_W-1:0]    a_lr_ff, b_lr_ff;
   logic [MAX_ROWS-1:0] a_rv_ff, b_rv_ff;
   logic [MAX_COLS-1:0] touched_ff;

   // walk
   logic [ROW_W-1:0]        row_ff;
   logic [NNZ_W-1:0]        j_ff, jend_ff, k_ff, kend_ff;
   logic [ROW_W-1:0]        ka_ff;
   logic [COL_W-1:0]        cb_ff, c_ff;
   logic signed [VAL_W-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [2*VAL_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;

   // magnitude
   logic signed [ACC_W-1:0] v_re_ff, v_im_ff;
   logic [ACC_W-1:0]        m_re_ff, m_im_ff;
   logic [ACC_W-1:0]        rhh_ff, rhl_ff, rll_ff, ihh_ff, ihl_ff, ill_ff;
   logic [SQ_W-1:0]         sq_re_ff, sq_im_ff;
   logic                    kept_ff;

   // pending kept entry and response register
   logic                    pend_valid_ff;
   logic [COL_W-1:0]        pend_col_ff;
   logic signed [ACC_W-1:0] pend_re_ff, pend_im_ff;
   logic                    out_valid_ff;
   rsp_word_type            out_ff;

   // ram ports
   logic [ENT_W-1:0]   a_ent_rd, b_ent_rd;
   logic [RNG_W-1:0]   a_rng_rd, b_rng_rd;
   logic [2*ACC_W-1:0] acc_rd;
   logic               acc_rd_en;
   logic [COL_W-1:0]   acc_rd_addr;

   // load decode
   logic               sel_b, is_load, load_ok;
   logic [DIM_W-1:0]   rlim, clim;
   logic [NNZ_W-1:0]   cnt, start_sel;
   logic [ROW_W-1:0]   lr;
   logic [1:0]         ld_status;
   logic               out_load;
   rsp_word_type       out_in;

   // mac
   logic signed [2*VAL_W:0] d_re, d_im;
   logic signed [ACC_W-1:0] cur_re, cur_im, new_re, new_im;
   logic [SQ_W-1:0]         total;

   assign sel_b   = (req_type == REQ_LOAD_B);
   assign is_load = (req_type == REQ_LOAD_A) || (req_type == REQ_LOAD_B);
   assign rlim    = sel_b ? inner_dim_ff : a_rows_ff;
   assign clim    = sel_b ? b_cols_ff : inner_dim_ff;
   assign cnt     = sel_b ? b_cnt_ff : a_cnt_ff;
   assign lr      = sel_b ? b_lr_ff : a_lr_ff;

   // row index is six bits, so the reset row limit of 64 is always met
   always_comb begin
      if (!({1'b0, req_row} < rlim) || !({1'b0, req_col} < clim)) begin
         ld_status = ST_RANGE;
      end else if (cnt != '0 && lr > req_row) begin
         ld_status = ST_ORDER;
      end else if (cnt == NNZ_W'(MAX_NNZ)) begin
         ld_status = ST_FULL;
      end else begin
         ld_status = ST_OK;
      end
   end

   assign load_ok   = cmd.accept && is_load && (ld_status == ST_OK);
   assign start_sel = (cnt != '0 && lr == req_row) ? (sel_b ? b_cs_ff : a_cs_ff) : cnt;

   // stores
   scmm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NNZ)) u_a_ent (
      .clock(clock), .wr_en(load_ok && !sel_b), .wr_addr(a_cnt_ff[ADDR_W-1:0]),
      .wr_data({req_col, req_val_im, req_val_re}),
      .rd_en(cmd.aent_rd), .rd_addr(j_ff[ADDR_W-1:0]), .rd_data(a_ent_rd));

   scmm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NNZ)) u_b_ent (
      .clock(clock), .wr_en(load_ok && sel_b), .wr_addr(b_cnt_ff[ADDR_W-1:0]),
      .wr_data({req_col, req_val_im, req_val_re}),
      .rd_en(cmd.bent_rd), .rd_addr(k_ff[ADDR_W-1:0]), .rd_data(b_ent_rd));

   scmm_ram #(.WIDTH(RNG_W), .DEPTH(MAX_ROWS)) u_a_rng (
      .clock(clock), .wr_en(load_ok && !sel_b), .wr_addr(req_row),
      .wr_data({start_sel, a_cnt_ff + NNZ_W'(1)}),
      .rd_en(cmd.arng_rd), .rd_addr(row_ff), .rd_data(a_rng_rd));

   scmm_ram #(.WIDTH(RNG_W), .DEPTH(MAX_ROWS)) u_b_rng (
      .clock(clock), .wr_en(load_ok && sel_b), .wr_addr(req_row),
      .wr_data({start_sel, b_cnt_ff + NNZ_W'(1)}),
      .rd_en(cmd.aent_take), .rd_addr(a_ent_rd[ENT_W-1 -: COL_W]), .rd_data(b_rng_rd));

   assign acc_rd_en   = cmd.bent_take || cmd.scan_rd;
   assign acc_rd_addr = cmd.bent_take ? b_ent_rd[ENT_W-1 -: COL_W] : c_ff;

   scmm_ram #(.WIDTH(2 * ACC_W), .DEPTH(MAX_COLS)) u_acc (
      .clock(clock), .wr_en(cmd.acc_add), .wr_addr(cb_ff), .wr_data({new_im, new_re}),
      .rd_en(acc_rd_en), .rd_addr(acc_rd_addr), .rd_data(acc_rd));

   // complex mac, untouched columns read as zero
   assign d_re   = (2*VAL_W+1)'(p_rr_ff) - (2*VAL_W+1)'(p_ii_ff);
   assign d_im   = (2*VAL_W+1)'(p_ri_ff) + (2*VAL_W+1)'(p_ir_ff);
   assign cur_re = touched_ff[cb_ff] ? acc_rd[ACC_W-1:0] : '0;
   assign cur_im = touched_ff[cb_ff] ? acc_rd[2*ACC_W-1:ACC_W] : '0;
   assign new_re = sat_acc((ACC_W+1)'(cur_re) + (ACC_W+1)'(d_re));
   assign new_im = sat_acc((ACC_W+1)'(cur_im) + (ACC_W+1)'(d_im));

   assign total = sq_re_ff + sq_im_ff;

   // response register source
   always_comb begin
      out_load = 1'b0;
      out_in   = out_ff;
      if (cmd.accept && !stat.go) begin
         out_load          = 1'b1;
         out_in.out_row    = req_row;
         out_in.out_col    = (req_type == REQ_COMPUTE) ? '0 : req_col;
         out_in.out_re     = '0;
         out_in.out_im     = '0;
         out_in.empty_row  = 1'b1;
         out_in.last       = 1'b1;
         out_in.status     = is_load ? ld_status :
                             ((req_type == REQ_COMPUTE) ? ST_RANGE : ST_OK);
      end else if (cmd.keep_step && stat.need_out) begin
         out_load          = 1'b1;
         out_in.out_row    = row_ff;
         out_in.out_col    = pend_col_ff;
         out_in.out_re     = pend_re_ff;
         out_in.out_im     = pend_im_ff;
         out_in.empty_row  = 1'b0;
         out_in.last       = 1'b0;
         out_in.status     = ST_OK;
      end else if (cmd.finish) begin
         out_load          = 1'b1;
         out_in.out_row    = row_ff;
         out_in.out_col    = pend_valid_ff ? pend_col_ff : '0;
         out_in.out_re     = pend_valid_ff ? pend_re_ff : '0;
         out_in.out_im     = pend_valid_ff ? pend_im_ff : '0;
         out_in.empty_row  = !pend_valid_ff;
         out_in.last       = 1'b1;
         out_in.status     = ST_OK;
      end
   end

   always_comb begin
      stat.out_free = !out_valid_ff || rsp.ready;
      stat.go       = (req_type == REQ_COMPUTE) && ({1'b0, req_row} < a_rows_ff);
      stat.a_more   = j_ff < jend_ff;
      stat.b_more   = k_ff < kend_ff;
      stat.touched  = touched_ff[c_ff];
      stat.need_out = kept_ff && pend_valid_ff;
      stat.last_col = (c_ff == COL_W'(MAX_COLS - 1));
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff     <= DIM_W'(MAX_ROWS);
         inner_dim_ff  <= DIM_W'(MAX_ROWS);
         b_cols_ff     <= DIM_W'(MAX_COLS);
         eps_sq_ff     <= '0;
         a_cnt_ff      <= '0;
         b_cnt_ff      <= '0;
         a_rv_ff       <= '0;
         b_rv_ff       <= '0;
         touched_ff    <= '0;
         c_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr_index_type'(csr.index))
               CSR_A_ROWS:    a_rows_ff    <= csr.data[DIM_W-1:0];
               CSR_INNER_DIM: inner_dim_ff <= csr.data[DIM_W-1:0];
               CSR_B_COLS:    b_cols_ff    <= csr.data[DIM_W-1:0];
               CSR_EPS_SQ:    eps_sq_ff    <= csr.data;
               default: ;
            endcase
         end
         if (load_ok && !sel_b) begin
            a_cnt_ff         <= a_cnt_ff + NNZ_W'(1);
            a_rv_ff[req_row] <= 1'b1;
         end
         if (load_ok && sel_b) begin
            b_cnt_ff         <= b_cnt_ff + NNZ_W'(1);
            b_rv_ff[req_row] <= 1'b1;
         end
         if (cmd.accept && req_type == REQ_CLEAR) begin
            a_cnt_ff <= '0;
            b_cnt_ff <= '0;
            a_rv_ff  <= '0;
            b_rv_ff  <= '0;
         end
         if (cmd.accept && stat.go) begin
            c_ff <= '0;
         end
         if (cmd.acc_add) begin
            touched_ff[cb_ff] <= 1'b1;
         end
         if (cmd.col_step) begin
            touched_ff[c_ff] <= 1'b0;
            c_ff             <= c_ff + COL_W'(1);
         end
         if (cmd.keep_step && kept_ff) begin
            pend_valid_ff <= 1'b1;
         end
         if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load_ok) begin
         if (sel_b) begin
            b_lr_ff <= req_row;
            b_cs_ff <= start_sel;
         end else begin
            a_lr_ff <= req_row;
            a_cs_ff <= start_sel;
         end
      end
      if (cmd.accept) begin
         row_ff <= req_row;
      end
      if (cmd.arng_take) begin
         j_ff    <= a_rv_ff[row_ff] ? a_rng_rd[RNG_W-1:NNZ_W] : '0;
         jend_ff <= a_rv_ff[row_ff] ? a_rng_rd[NNZ_W-1:0] : '0;
      end
      if (cmd.aent_take) begin
         ar_ff <= a_ent_rd[VAL_W-1:0];
         ai_ff <= a_ent_rd[2*VAL_W-1:VAL_W];
         ka_ff <= a_ent_rd[ENT_W-1 -: COL_W];
         j_ff  <= j_ff + NNZ_W'(1);
      end
      if (cmd.brng_take) begin
         k_ff    <= b_rv_ff[ka_ff] ? b_rng_rd[RNG_W-1:NNZ_W] : '0;
         kend_ff <= b_rv_ff[ka_ff] ? b_rng_rd[NNZ_W-1:0] : '0;
      end
      if (cmd.bent_take) begin
         br_ff <= b_ent_rd[VAL_W-1:0];
         bi_ff <= b_ent_rd[2*VAL_W-1:VAL_W];
         cb_ff <= b_ent_rd[ENT_W-1 -: COL_W];
         k_ff  <= k_ff + NNZ_W'(1);
      end
      if (cmd.mul) begin
         p_rr_ff <= ar_ff * br_ff;
         p_ii_ff <= ai_ff * bi_ff;
         p_ri_ff <= ar_ff * bi_ff;
         p_ir_ff <= ai_ff * br_ff;
      end
      if (cmd.mag1) begin
         v_re_ff <= acc_rd[ACC_W-1:0];
         v_im_ff <= acc_rd[2*ACC_W-1:ACC_W];
         m_re_ff <= abs_acc(acc_rd[ACC_W-1:0]);
         m_im_ff <= abs_acc(acc_rd[2*ACC_W-1:ACC_W]);
      end
      if (cmd.mag2) begin
         rhh_ff <= m_re_ff[ACC_W-1:HALF_W] * m_re_ff[ACC_W-1:HALF_W];
         rhl_ff <= m_re_ff[ACC_W-1:HALF_W] * m_re_ff[HALF_W-1:0];
         rll_ff <= m_re_ff[HALF_W-1:0] * m_re_ff[HALF_W-1:0];
         ihh_ff <= m_im_ff[ACC_W-1:HALF_W] * m_im_ff[ACC_W-1:HALF_W];
         ihl_ff <= m_im_ff[ACC_W-1:HALF_W] * m_im_ff[HALF_W-1:0];
         ill_ff <= m_im_ff[HALF_W-1:0] * m_im_ff[HALF_W-1:0];
      end
      if (cmd.mag3) begin
         // (h*2^20 + l)^2 = h^2*2^40 + hl*2^21 + l^2
         sq_re_ff <= {rhh_ff, {ACC_W{1'b0}}} + (SQ_W'(rhl_ff) << (HALF_W + 1)) + SQ_W'(rll_ff);
         sq_im_ff <= {ihh_ff, {ACC_W{1'b0}}} + (SQ_W'(ihl_ff) << (HALF_W + 1)) + SQ_W'(ill_ff);
      end
      if (cmd.mag4) begin
         kept_ff <= EPS_W'(total[SQ_W-1:32]) > eps_sq_ff;
      end
      if (cmd.keep_step && kept_ff) begin
         pend_col_ff <= c_ff;
         pend_re_ff  <= v_re_ff;
         pend_im_ff  <= v_im_ff;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign csr.ready     = 1'b1;
   assign rsp.valid     = out_valid_ff;
   assign rsp.out_row   = out_ff.out_row;
   assign rsp.out_col   = out_ff.out_col;
   assign rsp.out_re    = out_ff.out_re;
   assign rsp.out_im    = out_ff.out_im;
   assign rsp.empty_row = out_ff.empty_row;
   assign rsp.last      = out_ff.last;
   assign rsp.status    = out_ff.status;

endmodule

`default_nettype wire

// ----- src/scmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// scmm_ctrl
// Sequencer: request acceptance, row walk, column scan and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module scmm_ctrl import scmm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_ARNG, S_ARNG_W, S_ACHK, S_AENT_W, S_BRNG_W, S_BCHK, S_BENT_W,
      S_MUL, S_ADD, S_SCAN, S_MAG1, S_MAG2, S_MAG3, S_MAG4, S_DEC, S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE) && stat.out_free;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (stat.go) state_in = S_ARNG;
            end
         end
         S_ARNG: begin
            cmd.arng_rd = 1'b1;
            state_in    = S_ARNG_W;
         end
         S_ARNG_W: begin
            cmd.arng_take = 1'b1;
            state_in      = S_ACHK;
         end
         S_ACHK: begin
            if (stat.a_more) begin
               cmd.aent_rd = 1'b1;
               state_in    = S_AENT_W;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_AENT_W: begin
            cmd.aent_take = 1'b1;
            state_in      = S_BRNG_W;
         end
         S_BRNG_W: begin
            cmd.brng_take = 1'b1;
            state_in      = S_BCHK;
         end
         S_BCHK: begin
            if (stat.b_more) begin
               cmd.bent_rd = 1'b1;
               state_in    = S_BENT_W;
            end else begin
               state_in = S_ACHK;
            end
         end
         S_BENT_W: begin
            cmd.bent_take = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.acc_add = 1'b1;
            state_in    = S_BCHK;
         end
         S_SCAN: begin
            if (stat.touched) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_MAG1;
            end else begin
               cmd.col_step = 1'b1;
               state_in     = stat.last_col ? S_FIN : S_SCAN;
            end
         end
         S_MAG1: begin
            cmd.mag1 = 1'b1;
            state_in = S_MAG2;
         end
         S_MAG2: begin
            cmd.mag2 = 1'b1;
            state_in = S_MAG3;
         end
         S_MAG3: begin
            cmd.mag3 = 1'b1;
            state_in = S_MAG4;
         end
         S_MAG4: begin
            cmd.mag4 = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (!stat.need_out || stat.out_free) begin
               cmd.keep_step = 1'b1;
               cmd.col_step  = 1'b1;
               state_in      = stat.last_col ? S_FIN : S_SCAN;
            end
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/sparse_complex_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// sparse_complex_matrix_multiply
// Row-by-row product of two sparse complex matrices held in compressed rows.
// ----------------------------------------------------------------------------
// Words on req_bus load nonzeros of A or B (in nondecreasing row order), clear
// both matrices, or ask for one row of A x B. Loads, clears and rejected
// requests give one acknowledge word each. A row compute fetches the row's
// A range and walks the row's A nonzeros (entry read, B row-range fetch) and,
// for each, the nonzeros of the matching B row (entry read, accumulator
// read, four 16x16 multiplies, saturating add), and ends with an end-of-walk
// check. The column walk then steps over each untouched column and takes
// each touched one through accumulator read, 40-bit squares split into 20x20
// partial products and threshold compare, then closes the row; any back
// pressure on rsp_bus stretches the row. One item is in work at a time; a
// request is taken only when the response register is free, at the earliest
// in the cycle in which the previous last word leaves.
// Kept entries come out in ascending column order with last on the final
// one; a row with nothing kept gives a single empty_row word. The stores
// need no clearing pass after reset: row valid bits and entry counts cover
// them. Register writes on csr_bus are taken in any cycle but only belong
// between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_complex_matrix_multiply import scmm_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   scmm_req_if.sink   req_bus,
   scmm_rsp_if.source rsp_bus,
   scmm_csr_if.sink   csr_bus
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   // sequencer
   scmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // stores, MAC, magnitude test and response register
   scmm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_type   (req_bus.req_type),
      .req_row    (req_bus.row),
      .req_col    (req_bus.col),
      .req_val_re (req_bus.val_re),
      .req_val_im (req_bus.val_im),
      .csr        (csr_bus),
      .rsp        (rsp_bus)
   );

   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire

// ----- src/scmm_checker.sv -----
// ----------------------------------------------------------------------------
// scmm_checker
// Port-level checks of the sparse complex matrix multiply.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_complex_matrix_multiply_assert.svh"

module scmm_checker import scmm_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_empty_row,
   input wire logic       rsp_last,
   input wire logic [1:0] rsp_status
);

   `SCMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
   `SCMM_ASSERT_IMPLY(a_no_take_stalled, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken with response stalled")
   `SCMM_ASSERT_IMPLY(a_empty_last, clock, reset, rsp_valid && rsp_empty_row, rsp_last, "empty word not last")
   `SCMM_ASSERT_IMPLY(a_err_empty, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_empty_row, "error word carries data")
   `SCMM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

endmodule

bind sparse_complex_matrix_multiply scmm_checker u_scmm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_empty_row (rsp_bus.empty_row),
   .rsp_last      (rsp_bus.last),
   .rsp_status    (rsp_bus.status)
);

`default_nettype wire
